@@ rtl/cpc_pkg.sv @@
// shared types, constants and the coin value table for the coin pulse classifier
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

  localparam int LEVEL_BITS  = 10;
  localparam int LEVEL_REGS  = 5;
  localparam int COUNT_BITS  = 16;
  localparam int TOTAL_BITS  = 26;
  localparam int INDEX_BITS  = 3;
  localparam int OP_BITS     = 2;

  localparam logic [OP_BITS-1:0] OP_SAMPLE   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_BASELINE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd2;

  localparam logic [INDEX_BITS-1:0] CFG_TOLERANCE = 3'd5;

  localparam logic [LEVEL_BITS-1:0] TOL_RESET  = 10'd30;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 16'd65535;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX  = 26'd57015450;

  localparam int ARM_MARGIN = 3;
  localparam int END_MARGIN = 2;

  typedef struct packed {
    logic                  hit;
    logic [INDEX_BITS-1:0] idx;
  } match_t;

  // coin value in grosz per slot
  function automatic logic [LEVEL_BITS-1:0] slot_value(input logic [INDEX_BITS-1:0] idx);
    logic [LEVEL_BITS-1:0] v;
    case (idx)
      3'd0:    v = 10'd20;
      3'd1:    v = 10'd50;
      3'd2:    v = 10'd100;
      3'd3:    v = 10'd200;
      3'd4:    v = 10'd500;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cpc_ifs.sv @@
// valid/ready channel interfaces for sample items, result items and config writes
`timescale 1ns / 1ps
`default_nettype none

interface cpc_in_if #(parameter int SAMPLE_BITS = 10);
  logic                         valid;
  logic                         ready;
  logic [cpc_pkg::OP_BITS-1:0]  op;
  logic [SAMPLE_BITS-1:0]       sample;
  modport source(output valid, op, sample, input ready);
  modport sink(input valid, op, sample, output ready);
endinterface

interface cpc_out_if #(parameter int SAMPLE_BITS = 10);
  logic                           valid;
  logic                           ready;
  logic                           coin_event;
  logic                           recognized;
  logic [cpc_pkg::INDEX_BITS-1:0] coin_index;
  logic [SAMPLE_BITS-1:0]         peak_level;
  logic [cpc_pkg::COUNT_BITS-1:0] coin_count;
  logic [cpc_pkg::TOTAL_BITS-1:0] total_grosz;
  modport source(output valid, coin_event, recognized, coin_index, peak_level,
                 coin_count, total_grosz, input ready);
  modport sink(input valid, coin_event, recognized, coin_index, peak_level,
               coin_count, total_grosz, output ready);
endinterface

interface cpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpc_pkg::INDEX_BITS-1:0] index;
  logic [cpc_pkg::LEVEL_BITS-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/cpc_match.sv @@
// parallel compare of the pulse peak against the slot levels, first match wins
`timescale 1ns / 1ps
`default_nettype none

module cpc_match #(
  parameter int ACTIVE = 5,
  parameter int CMP_W  = 10
) (
  input  wire logic [CMP_W-1:0]               peak,
  input  wire logic [cpc_pkg::LEVEL_BITS-1:0] level [cpc_pkg::LEVEL_REGS],
  input  wire logic [cpc_pkg::LEVEL_BITS-1:0] tol,
  output cpc_pkg::match_t                     match
);

  logic [CMP_W-1:0] lvl_ext [ACTIVE];
  logic [CMP_W-1:0] diff [ACTIVE];
  logic [ACTIVE-1:0] near;

  always_comb begin
    for (int i = 0; i < ACTIVE; i++) begin
      lvl_ext[i] = CMP_W'(level[i]);
      diff[i]    = (peak >= lvl_ext[i]) ? (peak - lvl_ext[i]) : (lvl_ext[i] - peak);
      near[i]    = diff[i] < CMP_W'(tol);
    end
  end

  // walk down so the lowest matching slot is the one kept
  always_comb begin
    match.hit = 1'b0;
    match.idx = '0;
    for (int i = ACTIVE - 1; i >= 0; i--) begin
      if (near[i]) begin
        match.hit = 1'b1;
        match.idx = cpc_pkg::INDEX_BITS'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/coin_pulse_classifier.sv @@
// top level: coin pulse peak tracking, slot classification, saturating counts and total
// an accepted item is held in the input register, then in the result register until taken
// throughput: one item per cycle unless stalled; input register, then classify + state update
// a held result stalls advance; the input register takes one more item and then stops
// reset (synchronous, rst_n low): baseline, peak, armed, counts and total cleared,
// slot levels cleared, tolerance set to 30, both pipeline registers empty
`timescale 1ns / 1ps
`default_nettype none

module coin_pulse_classifier #(
  parameter int NUM_SLOTS   = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cpc_in_if.sink    in_chan,
  cpc_out_if.source out_chan,
  cpc_cfg_if.sink   cfg_chan
);

  localparam int ACTIVE = (NUM_SLOTS < cpc_pkg::LEVEL_REGS) ? NUM_SLOTS : cpc_pkg::LEVEL_REGS;
  localparam int W      = SAMPLE_BITS;
  localparam int CMP_W  = (W > cpc_pkg::LEVEL_BITS) ? W : cpc_pkg::LEVEL_BITS;

  // configuration
  logic [cpc_pkg::LEVEL_BITS-1:0] level_r [cpc_pkg::LEVEL_REGS];
  logic [cpc_pkg::LEVEL_BITS-1:0] tol_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cpc_pkg::LEVEL_REGS; i++) begin
        level_r[i] <= '0;
      end
      tol_r <= cpc_pkg::TOL_RESET;
    end else if (cfg_chan.valid) begin
      for (int i = 0; i < cpc_pkg::LEVEL_REGS; i++) begin
        if (cfg_chan.index == cpc_pkg::INDEX_BITS'(i)) begin
          level_r[i] <= cfg_chan.data;
        end
      end
      if (cfg_chan.index == cpc_pkg::CFG_TOLERANCE) begin
        tol_r <= cfg_chan.data;
      end
    end
  end

  // pipeline control
  logic                        s1_valid_r;
  logic [cpc_pkg::OP_BITS-1:0] s1_op_r;
  logic [W-1:0]                s1_sample_r;
  logic                        out_valid_r;
  logic                        out_free;
  logic                        advance;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign advance       = s1_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_op_r     <= in_chan.op;
      s1_sample_r <= in_chan.sample;
    end
  end

  // classifier state
  logic [W-1:0]                   baseline_r, baseline_nxt;
  logic [W-1:0]                   peak_r, peak_nxt;
  logic                           armed_r, armed_nxt;
  logic [cpc_pkg::COUNT_BITS-1:0] cnt_r [ACTIVE];
  logic [cpc_pkg::COUNT_BITS-1:0] cnt_nxt [ACTIVE];
  logic [cpc_pkg::TOTAL_BITS-1:0] total_r, total_nxt;

  logic [W-1:0]                   peak_max;
  logic [W-1:0]                   base_diff;
  logic                           rise;
  logic                           close;
  logic                           end_ev;
  cpc_pkg::match_t                match;
  logic [cpc_pkg::TOTAL_BITS-1:0] sum;
  logic [cpc_pkg::COUNT_BITS-1:0] sel_cnt;

  logic                           ev;
  logic                           rec;
  logic [cpc_pkg::INDEX_BITS-1:0] idx;
  logic [W-1:0]                   pk;
  logic [cpc_pkg::COUNT_BITS-1:0] cnt_out;

  assign peak_max  = (s1_sample_r > peak_r) ? s1_sample_r : peak_r;
  assign base_diff = (s1_sample_r >= baseline_r) ? (s1_sample_r - baseline_r)
                                                  : (baseline_r - s1_sample_r);
  assign rise      = {1'b0, s1_sample_r} > ({1'b0, baseline_r} + (W+1)'(cpc_pkg::ARM_MARGIN));
  assign close     = base_diff < W'(cpc_pkg::END_MARGIN);
  // a rising sample can never be close, so only the stored arm can end a pulse
  assign end_ev    = (s1_op_r == cpc_pkg::OP_SAMPLE) && armed_r && close;

  cpc_match #(
    .ACTIVE (ACTIVE),
    .CMP_W  (CMP_W)
  ) u_match (
    .peak  (CMP_W'(peak_max)),
    .level (level_r),
    .tol   (tol_r),
    .match (match)
  );

  assign sum = total_r + cpc_pkg::TOTAL_BITS'(cpc_pkg::slot_value(match.idx));

  always_comb begin
    sel_cnt = '0;
    for (int i = 0; i < ACTIVE; i++) begin
      if (match.idx == cpc_pkg::INDEX_BITS'(i)) begin
        sel_cnt = cnt_r[i];
      end
    end
  end

  always_comb begin
    baseline_nxt = baseline_r;
    peak_nxt     = peak_r;
    armed_nxt    = armed_r;
    total_nxt    = total_r;
    for (int i = 0; i < ACTIVE; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    ev      = 1'b0;
    rec     = 1'b0;
    idx     = '0;
    pk      = '0;
    cnt_out = '0;
    unique case (s1_op_r)
      cpc_pkg::OP_SAMPLE: begin
        peak_nxt = peak_max;
        if (rise) begin
          armed_nxt = 1'b1;
        end
        if (end_ev) begin
          ev = 1'b1;
          pk = peak_max;
          if (match.hit) begin
            rec     = 1'b1;
            idx     = match.idx;
            cnt_out = (sel_cnt != cpc_pkg::COUNT_MAX) ? sel_cnt + 1'b1 : sel_cnt;
            for (int i = 0; i < ACTIVE; i++) begin
              if (match.idx == cpc_pkg::INDEX_BITS'(i)) begin
                cnt_nxt[i] = cnt_out;
              end
            end
            total_nxt = (sum > cpc_pkg::TOTAL_MAX) ? cpc_pkg::TOTAL_MAX : sum;
          end
          armed_nxt = 1'b0;
          peak_nxt  = baseline_r;
        end
      end
      cpc_pkg::OP_BASELINE: begin
        baseline_nxt = s1_sample_r;
        peak_nxt     = s1_sample_r;
      end
      cpc_pkg::OP_CLEAR: begin
        for (int i = 0; i < ACTIVE; i++) begin
          cnt_nxt[i] = '0;
        end
        total_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= '0;
      peak_r     <= '0;
      armed_r    <= 1'b0;
      total_r    <= '0;
      for (int i = 0; i < ACTIVE; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (advance) begin
      baseline_r <= baseline_nxt;
      peak_r     <= peak_nxt;
      armed_r    <= armed_nxt;
      total_r    <= total_nxt;
      for (int i = 0; i < ACTIVE; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // result register
  logic                           ev_r;
  logic                           rec_r;
  logic [cpc_pkg::INDEX_BITS-1:0] idx_r;
  logic [W-1:0]                   pk_r;
  logic [cpc_pkg::COUNT_BITS-1:0] cnt_out_r;
  logic [cpc_pkg::TOTAL_BITS-1:0] total_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r        <= ev;
      rec_r       <= rec;
      idx_r       <= idx;
      pk_r        <= pk;
      cnt_out_r   <= cnt_out;
      total_out_r <= total_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.coin_event  = ev_r;
  assign out_chan.recognized  = rec_r;
  assign out_chan.coin_index  = idx_r;
  assign out_chan.peak_level  = pk_r;
  assign out_chan.coin_count  = cnt_out_r;
  assign out_chan.total_grosz = total_out_r;

endmodule

`default_nettype wire
